>>> rtl/fwb_pkg.sv
// Shared types and constants of the fixed-weight beamformer.
`default_nettype none

package fwb_pkg;

  // Widths of the item fields
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int COEF_W   = 16;
  localparam int STAT_W   = 2;
  localparam int PROD_W   = 32;
  localparam int VALUE_W  = 36;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Results per row never exceed this count
  localparam int RESULT_LIMIT = 16;

  // Request opcodes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Frame status codes
  localparam logic [STAT_W-1:0] STATUS_GOOD    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAMS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT   = 2'd2;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         beam_sel;
    logic [IDX_W-1:0]         channel_sel;
    logic signed [COEF_W-1:0] weight;
    logic signed [COEF_W-1:0] sample;
    logic [STAT_W-1:0]        frm_status;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          out_index;
    logic                      bypassed;
    logic [STAT_W-1:0]         row_status;
    logic                      last;
  } out_t;

  // Tag that travels with each memory read through the MAC pipeline
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic              first;
    logic              lastc;
    logic              bypass;
    logic              last;
    logic [STAT_W-1:0] row_status;
  } tag_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             wr_weight;
    logic             wr_sample;
    logic             rd;
    logic [IDX_W-1:0] rd_beam;
    logic [IDX_W-1:0] rd_chan;
    tag_t             tag;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/fwb_ctrl.sv
// Controller of the beamformer: configuration, row status and MAC sequencing.
`default_nettype none

module fwb_ctrl #(
  parameter int MAX_BEAMS    = 16,
  parameter int MAX_CHANNELS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  fwb_pkg::in_t                    in_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [fwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [fwb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  fwb_pkg::status_t                dp_status,
  output fwb_pkg::cmd_t                   cmd
);

  localparam int CH_BOUND = (MAX_CHANNELS < fwb_pkg::RESULT_LIMIT) ?
                            MAX_CHANNELS : fwb_pkg::RESULT_LIMIT;
  localparam int BM_BOUND = (MAX_BEAMS < fwb_pkg::RESULT_LIMIT) ?
                            MAX_BEAMS : fwb_pkg::RESULT_LIMIT;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;

  localparam logic [fwb_pkg::CNT_W-1:0] ONE = 5'd1;

  logic [1:0] state_r, state_nxt;
  logic [fwb_pkg::CNT_W-1:0] chans_r, chans_nxt;
  logic [fwb_pkg::CNT_W-1:0] beams_r, beams_nxt;
  logic accept_inv_r, accept_inv_nxt;
  logic [fwb_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [fwb_pkg::STAT_W-1:0] rs_r, rs_nxt;
  logic byp_r, byp_nxt;
  logic [fwb_pkg::IDX_W-1:0] item_r, item_nxt;
  logic [fwb_pkg::IDX_W-1:0] chan_r, chan_nxt;

  logic [fwb_pkg::CNT_W-1:0] nch, nbm, nitems;
  logic accept, in_row, row_end;
  logic [fwb_pkg::STAT_W-1:0] samp_st, st_max;
  logic chan_last, item_last;

  // Map a count register to its effective value: zero acts as one, clip at bound
  function automatic logic [fwb_pkg::CNT_W-1:0] clamp_count(
    input logic [fwb_pkg::CNT_W-1:0] v,
    input logic [fwb_pkg::CNT_W-1:0] bound
  );
    logic [fwb_pkg::CNT_W-1:0] r;
    if (v == '0) begin
      r = ONE;
    end else if (v > bound) begin
      r = bound;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign nch = clamp_count(chans_r, fwb_pkg::CNT_W'(CH_BOUND));
  assign nbm = clamp_count(beams_r, fwb_pkg::CNT_W'(BM_BOUND));
  assign nitems = byp_r ? nch : nbm;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // Decode the incoming sample against the row
  assign samp_st = (in_data.frm_status > fwb_pkg::STATUS_INVALID) ?
                   fwb_pkg::STATUS_INVALID : in_data.frm_status;
  assign st_max  = (samp_st > status_r) ? samp_st : status_r;
  assign in_row  = {1'b0, in_data.channel_sel} < nch;
  assign row_end = in_row && ({1'b0, in_data.channel_sel} == nch - ONE);

  assign chan_last = ({1'b0, chan_r} == nch - ONE);
  assign item_last = ({1'b0, item_r} == nitems - ONE);

  // Take configuration writes
  always_comb begin
    chans_nxt      = chans_r;
    beams_nxt      = beams_r;
    accept_inv_nxt = accept_inv_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fwb_pkg::CFG_CHANNELS: chans_nxt      = cfg_data;
        fwb_pkg::CFG_BEAMS:    beams_nxt      = cfg_data;
        fwb_pkg::CFG_ACCEPT:   accept_inv_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequence requests, then one MAC pass per beam or one read per bypassed channel
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    rs_nxt     = rs_r;
    byp_nxt    = byp_r;
    item_nxt   = item_r;
    chan_nxt   = chan_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == fwb_pkg::OP_WEIGHT) begin
            cmd.wr_weight = (int'(in_data.beam_sel) < MAX_BEAMS) &&
                            (int'(in_data.channel_sel) < MAX_CHANNELS);
          end else if (in_row) begin
            cmd.wr_sample = 1'b1;
            status_nxt    = st_max;
            if (row_end) begin
              status_nxt = fwb_pkg::STATUS_GOOD;
              rs_nxt     = st_max;
              byp_nxt    = (st_max == fwb_pkg::STATUS_INVALID) && !accept_inv_r;
              item_nxt   = '0;
              chan_nxt   = '0;
              state_nxt  = S_WAIT;
            end
          end
        end
      end
      S_WAIT: begin
        if (!dp_status.pipe_busy) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd             = 1'b1;
        cmd.rd_beam        = item_r;
        cmd.rd_chan        = byp_r ? item_r : chan_r;
        cmd.tag.index      = item_r;
        cmd.tag.bypass     = byp_r;
        cmd.tag.row_status = rs_r;
        cmd.tag.first      = byp_r || (chan_r == '0);
        cmd.tag.lastc      = byp_r || chan_last;
        cmd.tag.last       = cmd.tag.lastc && item_last;
        if (cmd.tag.lastc) begin
          chan_nxt  = '0;
          item_nxt  = item_r + 1'b1;
          state_nxt = item_last ? S_IDLE : S_WAIT;
        end else begin
          chan_nxt = chan_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chans_r      <= 5'd16;
      beams_r      <= 5'd16;
      accept_inv_r <= 1'b0;
      status_r     <= fwb_pkg::STATUS_GOOD;
      rs_r         <= fwb_pkg::STATUS_GOOD;
      byp_r        <= 1'b0;
      item_r       <= '0;
      chan_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      chans_r      <= chans_nxt;
      beams_r      <= beams_nxt;
      accept_inv_r <= accept_inv_nxt;
      status_r     <= status_nxt;
      rs_r         <= rs_nxt;
      byp_r        <= byp_nxt;
      item_r       <= item_nxt;
      chan_r       <= chan_nxt;
    end
  end

  // Reads stay inside the row and the result count
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (({1'b0, chan_r} < nch) && ({1'b0, item_r} < nitems)))
    else $error("read issued outside the row");

  // The row status starts over after the end of a row
  a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == fwb_pkg::OP_SAMPLE && row_end) |=>
      (status_r == fwb_pkg::STATUS_GOOD && state_r == S_WAIT))
    else $error("row status not cleared at end of row");

endmodule

`default_nettype wire

>>> rtl/fwb_dp.sv
// Datapath of the beamformer: weight and row memories, MAC pipeline, output register.
`default_nettype none

module fwb_dp #(
  parameter int MAX_BEAMS    = 16,
  parameter int MAX_CHANNELS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  fwb_pkg::in_t      in_data,
  input  fwb_pkg::cmd_t     cmd,
  output fwb_pkg::status_t  dp_status,
  output logic              out_valid,
  input  wire               out_stall,
  output fwb_pkg::out_t     out_data
);

  localparam int WDEPTH = MAX_BEAMS * MAX_CHANNELS;
  localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int RA     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [fwb_pkg::COEF_W-1:0] wmem [WDEPTH];
  logic signed [fwb_pkg::COEF_W-1:0] rmem [MAX_CHANNELS];

  logic [WA-1:0] w_waddr, w_raddr;
  logic [RA-1:0] r_waddr, r_raddr;

  logic signed [fwb_pkg::COEF_W-1:0] w_q_r, s_q_r;
  logic s1_valid_r;
  fwb_pkg::tag_t s1_tag_r;

  logic s2_valid_r;
  fwb_pkg::tag_t s2_tag_r;
  logic signed [fwb_pkg::PROD_W-1:0] prod_r;
  logic signed [fwb_pkg::COEF_W-1:0] samp_r;

  logic signed [fwb_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic signed [fwb_pkg::VALUE_W-1:0] prod_ext, sum;
  logic out_valid_r, out_valid_nxt;
  fwb_pkg::out_t out_data_r, out_data_nxt;
  logic done;

  // Address the memories
  assign w_waddr = WA'(int'(in_data.beam_sel) * MAX_CHANNELS + int'(in_data.channel_sel));
  assign w_raddr = WA'(int'(cmd.rd_beam) * MAX_CHANNELS + int'(cmd.rd_chan));
  assign r_waddr = RA'(int'(in_data.channel_sel));
  assign r_raddr = RA'(int'(cmd.rd_chan));

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      wmem[w_waddr] <= in_data.weight;
    end
    if (cmd.rd) begin
      w_q_r <= wmem[w_raddr];
    end
  end

  // Row buffer memory
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      rmem[r_waddr] <= in_data.sample;
    end
    if (cmd.rd) begin
      s_q_r <= rmem[r_raddr];
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    s2_tag_r <= s1_tag_r;
    prod_r   <= w_q_r * s_q_r;
    samp_r   <= s_q_r;
    s1_tag_r <= cmd.tag;
  end

  // Accumulate and form the result
  assign prod_ext = {{(fwb_pkg::VALUE_W - fwb_pkg::PROD_W){prod_r[fwb_pkg::PROD_W-1]}},
                     prod_r};
  assign sum  = s2_tag_r.first ? prod_ext : acc_r + prod_ext;
  assign done = s2_valid_r && s2_tag_r.lastc;

  always_comb begin
    acc_nxt       = s2_valid_r ? sum : acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (done) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.value      = s2_tag_r.bypass ?
        {{(fwb_pkg::VALUE_W - fwb_pkg::COEF_W){samp_r[fwb_pkg::COEF_W-1]}}, samp_r} : sum;
      out_data_nxt.out_index  = s2_tag_r.index;
      out_data_nxt.bypassed   = s2_tag_r.bypass;
      out_data_nxt.row_status = s2_tag_r.row_status;
      out_data_nxt.last       = s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= cmd.rd;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Busy while reads are in flight or a result is held by the receiver
  assign dp_status.pipe_busy = s1_valid_r || s2_valid_r || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !done)
    else $error("result overwritten while stalled");

  // Bypassed requests are single reads
  a_bypass_single: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_tag_r.bypass) |-> (s2_tag_r.first && s2_tag_r.lastc))
    else $error("bypass request spans several reads");

endmodule

`default_nettype wire

>>> rtl/fixed_weight_beamformer.sv
// Top level of the fixed-weight beamformer: controller plus datapath.
//
// Input channel (in_valid/in_stall/in_data) carries weight writes and channel
// samples. A weight write, or a sample that does not end a row, is taken without a stall.
// The sample on the last channel in use starts the row pass: for each beam in
// use, one MAC unit reads weight and row memories once per channel (one read
// port each); a bypassed row instead reads each channel once. Each beam or
// bypassed channel starts only when the pipeline has drained and any earlier
// result has left. A result passes the memory read registers and the product
// register into the output register.
// in_stall is high for the whole row pass.
// Result channel (out_valid/out_stall/out_data) is fed from one output
// register; a stalled result holds and the next beam waits for it.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready:
// index 0 channel count, 1 beam count, 2 accept-invalid flag.
// Synchronous reset clears control state and restores 16 channels, 16 beams and
// bypass of invalid rows; weight and row memories hold no defined value until
// written, and no clearing pass runs.
`default_nettype none

module fixed_weight_beamformer #(
  parameter int MAX_BEAMS    = 16,
  parameter int MAX_CHANNELS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  fwb_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output fwb_pkg::out_t                   out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [fwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [fwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fwb_pkg::cmd_t    cmd;
  fwb_pkg::status_t dp_status;

  // Sequence rows and configuration
  fwb_ctrl #(
    .MAX_BEAMS    (MAX_BEAMS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Store weights and samples, run the MAC
  fwb_dp #(
    .MAX_BEAMS    (MAX_BEAMS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .dp_status (dp_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the fixed-weight beamformer against a beam-sum predictor.

module tb;

  localparam int MAX_BEAMS    = 16;
  localparam int MAX_CHANNELS = 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD    = 400;

  // Status codes the package leaves unnamed
  localparam logic [fwb_pkg::STAT_W-1:0] STATUS_PARTIAL  = 2'd1;
  localparam logic [fwb_pkg::STAT_W-1:0] STATUS_RESERVED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  fwb_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  fwb_pkg::out_t                  out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fwb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fwb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fixed_weight_beamformer #(
    .MAX_BEAMS(MAX_BEAMS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: weight matrix, row buffer, status and registers
  logic signed [fwb_pkg::COEF_W-1:0] coef_mem [MAX_BEAMS][MAX_CHANNELS];
  logic signed [fwb_pkg::COEF_W-1:0] row_mem [MAX_CHANNELS];
  logic [fwb_pkg::STAT_W-1:0]        status_acc = fwb_pkg::STATUS_GOOD;
  logic [fwb_pkg::CNT_W-1:0]         reg_channels = 5'd16;
  logic [fwb_pkg::CNT_W-1:0]         reg_beams = 5'd16;
  logic                              reg_accept = 1'b0;

  fwb_pkg::out_t beam_results_due [$];
  fwb_pkg::in_t  pending_requests [$];

  // Generator view of what has been written, so no unwritten entry is read
  bit coef_set [MAX_BEAMS][MAX_CHANNELS];
  bit row_set [MAX_CHANNELS];
  int gen_ch = 16;
  int gen_bm = 16;
  int gen_count = 0;

  bit   idle_on = 1'b1;
  bit   in_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   cycles = 0;
  int   faults = 0;
  int   requests_done = 0;
  int   results_seen = 0;
  int   rows_passed = 0;
  int   rows_combined = 0;
  fwb_pkg::out_t due;

  function automatic int eff_count(input logic [fwb_pkg::CNT_W-1:0] v, input int bound);
    if (v == 0) return 1;
    if (v > bound) return bound;
    return int'(v);
  endfunction

  // Mostly no gap or a short one, now and then a long one
  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [fwb_pkg::COEF_W-1:0] rand_q15();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'h0000;
    return fwb_pkg::COEF_W'($urandom);
  endfunction

  function automatic logic [fwb_pkg::STAT_W-1:0] rand_mild_status();
    return ($urandom_range(0, 3) == 0) ? STATUS_PARTIAL : fwb_pkg::STATUS_GOOD;
  endfunction

  // Update state for one request and queue the beam sums or passed-through samples it causes
  function automatic void compute_beams(input fwb_pkg::in_t req);
    logic [fwb_pkg::STAT_W-1:0] st;
    logic [fwb_pkg::STAT_W-1:0] seen;
    int                         nch;
    int                         nbm;
    longint                     acc;
    fwb_pkg::out_t              res;
    nch = eff_count(reg_channels, MAX_CHANNELS);
    nbm = eff_count(reg_beams, MAX_BEAMS);
    if (req.op == fwb_pkg::OP_WEIGHT) begin
      coef_mem[req.beam_sel][req.channel_sel] = req.weight;
      return;
    end
    if (req.channel_sel >= nch) return;
    st = (req.frm_status > fwb_pkg::STATUS_INVALID) ? fwb_pkg::STATUS_INVALID
                                                     : req.frm_status;
    row_mem[req.channel_sel] = req.sample;
    if (st > status_acc) status_acc = st;
    if (req.channel_sel != nch - 1) return;
    seen = status_acc;
    status_acc = fwb_pkg::STATUS_GOOD;
    if (seen == fwb_pkg::STATUS_INVALID && !reg_accept) begin
      rows_passed++;
      for (int k = 0; k < nch; k++) begin
        res.value      = {{(fwb_pkg::VALUE_W - fwb_pkg::COEF_W){row_mem[k][fwb_pkg::COEF_W-1]}},
                          row_mem[k]};
        res.out_index  = fwb_pkg::IDX_W'(k);
        res.bypassed   = 1'b1;
        res.row_status = seen;
        res.last       = (k == nch - 1);
        beam_results_due.insert(beam_results_due.size(), res);
      end
    end else begin
      rows_combined++;
      for (int k = 0; k < nbm; k++) begin
        acc = 0;
        for (int c = 0; c < nch; c++)
          acc += longint'(coef_mem[k][c]) * longint'(row_mem[c]);
        res.value      = acc[fwb_pkg::VALUE_W-1:0];
        res.out_index  = fwb_pkg::IDX_W'(k);
        res.bypassed   = 1'b0;
        res.row_status = seen;
        res.last       = (k == nbm - 1);
        beam_results_due.insert(beam_results_due.size(), res);
      end
    end
  endfunction

  // Take a request at each accepting edge and predict it
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      requests_done++;
      compute_beams(in_data);
    end
  end

  // Offer queued requests with random gaps; hold a stalled request
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) begin
        in_taken = 1'b0;
        send_gap = idle_on ? pick_idle() : 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall results at random; a long hold overrides everything
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
        stall_left = pick_idle();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (beam_results_due.size() == 0) begin
        $error("result with nothing expected: out_index %0d value %0d",
               out_data.out_index, out_data.value);
        faults++;
      end else begin
        due = beam_results_due.pop_front();
        check_field("value", longint'(due.value), longint'(out_data.value));
        check_field("out_index", due.out_index, out_data.out_index);
        check_field("bypassed", due.bypassed, out_data.bypassed);
        check_field("row_status", due.row_status, out_data.row_status);
        check_field("last", due.last, out_data.last);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, beam_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [fwb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fwb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fwb_pkg::CFG_CHANNELS: reg_channels = data;
      fwb_pkg::CFG_BEAMS:    reg_beams = data;
      fwb_pkg::CFG_ACCEPT:   reg_accept = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input logic [fwb_pkg::CNT_W-1:0] ch,
                          input logic [fwb_pkg::CNT_W-1:0] bm,
                          input logic acc);
    write_reg(fwb_pkg::CFG_CHANNELS, ch);
    write_reg(fwb_pkg::CFG_BEAMS, bm);
    write_reg(fwb_pkg::CFG_ACCEPT, fwb_pkg::CFG_DATA_W'(acc));
    gen_ch = eff_count(ch, MAX_CHANNELS);
    gen_bm = eff_count(bm, MAX_BEAMS);
  endtask

  // Wait for the queue and expectations to drain, then let the block finish
  task automatic settle(input int extra);
    while (pending_requests.size() != 0 || in_valid || beam_results_due.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic push_weight(input int b, input int c, input logic [fwb_pkg::COEF_W-1:0] w);
    fwb_pkg::in_t req;
    req.op           = fwb_pkg::OP_WEIGHT;
    req.beam_sel     = fwb_pkg::IDX_W'(b);
    req.channel_sel  = fwb_pkg::IDX_W'(c);
    req.weight       = w;
    req.sample       = fwb_pkg::COEF_W'($urandom);
    req.frm_status   = fwb_pkg::STAT_W'($urandom_range(0, 3));
    pending_requests.insert(pending_requests.size(), req);
    coef_set[b][c] = 1'b1;
    gen_count++;
  endtask

  task automatic push_sample(input int c, input logic [fwb_pkg::COEF_W-1:0] s,
                             input logic [fwb_pkg::STAT_W-1:0] st);
    fwb_pkg::in_t req;
    req.op           = fwb_pkg::OP_SAMPLE;
    req.beam_sel     = fwb_pkg::IDX_W'($urandom);
    req.channel_sel  = fwb_pkg::IDX_W'(c);
    req.weight       = fwb_pkg::COEF_W'($urandom);
    req.sample       = s;
    req.frm_status   = st;
    pending_requests.insert(pending_requests.size(), req);
    if (c < gen_ch) begin
      row_set[c] = 1'b1;
      gen_count++;
    end
  endtask

  task automatic load_missing_weights();
    for (int b = 0; b < gen_bm; b++)
      for (int c = 0; c < gen_ch; c++)
        if (!coef_set[b][c]) push_weight(b, c, rand_q15());
  endtask

  // Fill any never-written channel, then send the closing sample
  task automatic close_row(input logic [fwb_pkg::STAT_W-1:0] st);
    for (int c = 0; c < gen_ch - 1; c++)
      if (!row_set[c]) push_sample(c, rand_q15(), rand_mild_status());
    push_sample(gen_ch - 1, rand_q15(), st);
  endtask

  // One complete row in channel order, sometimes with one invalid sample
  task automatic send_row();
    int bad;
    bad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, gen_ch - 1)) : -1;
    for (int c = 0; c < gen_ch; c++)
      push_sample(c, rand_q15(),
                  (c == bad) ? ($urandom_range(0, 1) ? fwb_pkg::STATUS_INVALID
                                                     : STATUS_RESERVED)
                             : rand_mild_status());
  endtask

  task automatic random_traffic(input int target);
    int stop;
    int r;
    int c;
    stop = gen_count + target;
    while (gen_count < stop) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_row();
      end else if (r < 70) begin
        // broken row: a few channels out of order, then the closing one
        if (gen_ch > 1)
          repeat ($urandom_range(0, 3))
            push_sample($urandom_range(0, gen_ch - 2), rand_q15(),
                        fwb_pkg::STAT_W'($urandom_range(0, 3)));
        close_row(fwb_pkg::STAT_W'($urandom_range(0, 3)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4))
          push_weight($urandom_range(0, MAX_BEAMS - 1), $urandom_range(0, MAX_CHANNELS - 1),
                      rand_q15());
      end else begin
        c = $urandom_range(0, MAX_CHANNELS - 1);
        if (c == gen_ch - 1) close_row(fwb_pkg::STAT_W'($urandom_range(0, 3)));
        else push_sample(c, rand_q15(), fwb_pkg::STAT_W'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: three channels, two beams, full-scale products
    set_mode(5'd3, 5'd2, 1'b0);
    push_weight(0, 0, 16'h7FFF);
    push_weight(0, 1, 16'h8000);
    push_weight(0, 2, 16'h0001);
    push_weight(1, 0, 16'h8000);
    push_weight(1, 1, 16'h8000);
    push_weight(1, 2, 16'hFFFF);
    push_weight(15, 15, 16'h1234);
    push_sample(0, 16'h8000, fwb_pkg::STATUS_GOOD);
    push_sample(1, 16'h8000, fwb_pkg::STATUS_GOOD);
    push_sample(2, 16'h7FFF, fwb_pkg::STATUS_GOOD);
    // outside the row: must not raise the status
    push_sample(15, 16'h7FFF, fwb_pkg::STATUS_INVALID);
    // partial row reusing the stale channel 1 sample
    push_sample(0, 16'h7FFF, STATUS_PARTIAL);
    push_sample(2, 16'h8000, fwb_pkg::STATUS_GOOD);
    // reserved status counts as invalid and bypasses
    push_sample(1, 16'h0000, STATUS_RESERVED);
    push_sample(0, 16'h0001, fwb_pkg::STATUS_GOOD);
    push_sample(2, 16'hFFFF, fwb_pkg::STATUS_GOOD);
    settle(SETTLE_CYCLES);
    // invalid row combined when accepted
    set_mode(5'd3, 5'd2, 1'b1);
    push_sample(0, 16'h7FFF, fwb_pkg::STATUS_INVALID);
    push_sample(1, 16'h7FFF, fwb_pkg::STATUS_GOOD);
    push_sample(2, 16'h8000, fwb_pkg::STATUS_GOOD);
    settle(SETTLE_CYCLES);

    // Zero counts act as one; no idling on either side
    idle_on = 1'b0;
    set_mode(5'd0, 5'd0, 1'b1);
    load_missing_weights();
    random_traffic(20);
    settle(SETTLE_CYCLES);

    idle_on = 1'b1;
    set_mode(5'd1, 5'd16, 1'b0);
    load_missing_weights();
    random_traffic(20);
    settle(SETTLE_CYCLES);

    set_mode(5'd16, 5'd1, 1'b1);
    load_missing_weights();
    random_traffic(20);
    settle(SETTLE_CYCLES);

    // Counts above the bound act as the full size in that dimension
    set_mode(5'd20, 5'd2, 1'b0);
    load_missing_weights();
    random_traffic(20);
    settle(SETTLE_CYCLES);

    set_mode(5'd2, 5'd31, 1'b1);
    load_missing_weights();
    random_traffic(20);
    settle(SETTLE_CYCLES);

    // Back-pressure: hold results off while requests keep coming
    set_mode(fwb_pkg::CNT_W'($urandom_range(2, 8)), fwb_pkg::CNT_W'($urandom_range(2, 8)),
             1'($urandom_range(0, 1)));
    load_missing_weights();
    @(posedge clk);
    hold_left = LONG_HOLD;
    send_row();
    send_row();
    random_traffic(10);
    settle(0);
    random_traffic(15);
    settle(SETTLE_CYCLES);

    $display("covered %0d requests: %0d rows combined, %0d rows passed through, %0d results",
             requests_done, rows_combined, rows_passed, results_seen);
    $display("channel/beam counts 3x2, 1x1, 1x16, 16x1, 16x2, 2x16 and a small random pair, %0d faults",
             faults);
    if (faults == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
